/* hdl/csfa_pkg.sv */
// Shared types and constants for the CAN slot frame aggregator.
package csfa_pkg;

    localparam int FRAME_BYTES  = 8;
    localparam int RESULT_LIMIT = 16;
    localparam int BUS_W        = 3;
    localparam int IDENT_W      = 29;
    localparam int GEOM_W       = 4;
    localparam int KEY_W        = BUS_W + IDENT_W + 2 * GEOM_W;
    localparam int DATA_W       = 8 * FRAME_BYTES;
    localparam int STATUS_W     = 3;

    typedef enum logic [1:0] {
        REQ_INGEST = 2'd0,
        REQ_CLEAR  = 2'd1,
        REQ_FLUSH  = 2'd2
    } csfa_req_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK          = 3'd0,
        STS_IGNORED     = 3'd1,
        STS_ZERO_SIZE   = 3'd2,
        STS_INDEX_RANGE = 3'd3,
        STS_OVER_BYTES  = 3'd4,
        STS_TABLE_FULL  = 3'd5,
        STS_NO_FRAMES   = 3'd6
    } csfa_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_READ,
        ST_EMIT
    } csfa_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic finish;
        logic scan_init;
        logic scan_step;
        logic emit_frame;
    } csfa_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic flush_frames;
        logic out_free;
        logic scan_last;
        logic frame_last;
    } csfa_sts_t;

endpackage

/* hdl/csfa_ctrl.sv */
// Controller state machine sequencing decode, flush scans and result loads.
module csfa_ctrl
    import csfa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  csfa_sts_t sts,
    output csfa_cmd_t cmd
);

    csfa_state_t state_reg;
    csfa_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (sts.flush_frames)
                begin
                    state_next = ST_SCAN;
                end
                else if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (sts.scan_last)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.frame_last ? ST_IDLE : ST_SCAN;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.capture = req_valid;
            end
            ST_DECODE:
            begin
                cmd.scan_init = sts.flush_frames;
                cmd.finish    = !sts.flush_frames && sts.out_free;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.emit_frame = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* hdl/csfa_dp.sv */
// Datapath: command registers, group table, frame memory, flush scan and result register.
module csfa_dp
    import csfa_pkg::*;
#(
    parameter int MAX_GROUPS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  csfa_cmd_t           cmd,
    output csfa_sts_t           sts,
    input  logic [1:0]          req_type,
    input  logic                cmd_valid,
    input  logic [BUS_W-1:0]    bus_number,
    input  logic [IDENT_W-1:0]  frame_ident,
    input  logic [GEOM_W-1:0]   slot_width,
    input  logic [GEOM_W-1:0]   slot_total,
    input  logic [GEOM_W-1:0]   slot_position,
    input  logic [DATA_W-1:0]   slot_payload,
    input  logic                res_ready,
    output logic                res_valid,
    output logic [BUS_W-1:0]    out_bus,
    output logic [IDENT_W-1:0]  out_ident,
    output logic [DATA_W-1:0]   out_data,
    output logic [STATUS_W-1:0] status,
    output logic                last_result
);

    localparam int IW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int CW = $clog2(MAX_GROUPS + 1);
    localparam int NW = (CW > 5) ? CW : 5;

    // Captured command.
    logic [1:0]         type_reg;
    logic               cmdv_reg;
    logic [BUS_W-1:0]   bus_reg;
    logic [IDENT_W-1:0] ident_reg;
    logic [GEOM_W-1:0]  width_reg;
    logic [GEOM_W-1:0]  total_reg;
    logic [GEOM_W-1:0]  pos_reg;
    logic [DATA_W-1:0]  payload_reg;

    // Group table.
    logic [MAX_GROUPS-1:0] used_reg;
    logic [KEY_W-1:0]      key_reg [MAX_GROUPS];
    logic [CW-1:0]         count_reg;
    logic [DATA_W-1:0]     frame_mem [MAX_GROUPS];
    logic [DATA_W-1:0]     rd_data_reg;

    // Flush scan.
    logic [IW-1:0]    scan_idx_reg;
    logic [IW-1:0]    best_idx_reg;
    logic [KEY_W-1:0] best_key_reg;
    logic             best_valid_reg;
    logic [KEY_W-1:0] prev_key_reg;
    logic             prev_valid_reg;
    logic [NW-1:0]    frame_cnt_reg;

    // Result register.
    logic                res_valid_reg;
    logic [BUS_W-1:0]    out_bus_reg;
    logic [IDENT_W-1:0]  out_ident_reg;
    logic [DATA_W-1:0]   out_data_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                last_reg;

    logic [KEY_W-1:0]    key_cmd;
    logic                match_any;
    logic [IW-1:0]       match_idx;
    logic                free_any;
    logic [IW-1:0]       free_idx;
    logic [7:0]          geom_prod;
    logic [7:0]          offs_prod;
    logic [2:0]          offs;
    logic [4:0]          offs_end;
    logic [FRAME_BYTES-1:0] byte_sel;
    logic [DATA_W-1:0]   shifted;
    logic [DATA_W-1:0]   wr_word;
    logic [IW-1:0]       wr_addr;
    csfa_status_t        ingest_code;
    csfa_status_t        finish_code;
    logic                commit;
    logic                alloc;
    logic                do_clear;
    logic                out_free;
    logic [KEY_W-1:0]    cand_key;
    logic                cand_ok;
    logic                scan_last;
    logic [NW-1:0]       frame_limit;
    logic [NW-1:0]       count_ext;
    logic                frame_last;

    assign key_cmd = {bus_reg, ident_reg, width_reg, total_reg};

    always_comb
    begin
        match_any = 1'b0;
        match_idx = '0;
        free_any  = 1'b0;
        free_idx  = '0;
        // Walking down leaves the lowest free entry selected.
        for (int i = MAX_GROUPS - 1; i >= 0; i--)
        begin
            if (used_reg[i] && (key_reg[i] == key_cmd))
            begin
                match_any = 1'b1;
                match_idx = IW'(i);
            end
            if (!used_reg[i])
            begin
                free_any = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    assign geom_prod = {4'b0, width_reg} * {4'b0, total_reg};
    assign offs_prod = {4'b0, pos_reg} * {4'b0, width_reg};
    assign offs      = offs_prod[2:0];
    assign offs_end  = {2'b0, offs} + {1'b0, width_reg};
    assign shifted   = payload_reg << {offs, 3'b000};

    always_comb
    begin
        for (int b = 0; b < FRAME_BYTES; b++)
        begin
            byte_sel[b]       = (5'(b) >= {2'b0, offs}) && (5'(b) < offs_end);
            wr_word[8*b +: 8] = byte_sel[b] ? shifted[8*b +: 8] : 8'h00;
        end
    end

    always_comb
    begin
        if (!cmdv_reg)
        begin
            ingest_code = STS_IGNORED;
        end
        else if ((width_reg == '0) || (total_reg == '0))
        begin
            ingest_code = STS_ZERO_SIZE;
        end
        else if (pos_reg >= total_reg)
        begin
            ingest_code = STS_INDEX_RANGE;
        end
        else if (geom_prod > 8'(FRAME_BYTES))
        begin
            ingest_code = STS_OVER_BYTES;
        end
        else if (!match_any && !free_any)
        begin
            ingest_code = STS_TABLE_FULL;
        end
        else
        begin
            ingest_code = STS_OK;
        end
    end

    always_comb
    begin
        case (type_reg)
            REQ_INGEST: finish_code = ingest_code;
            REQ_CLEAR:  finish_code = STS_OK;
            REQ_FLUSH:  finish_code = STS_NO_FRAMES;
            default:    finish_code = STS_IGNORED;
        endcase
    end

    assign commit   = cmd.finish && (type_reg == REQ_INGEST) && (ingest_code == STS_OK);
    assign alloc    = commit && !match_any;
    assign do_clear = cmd.finish && (type_reg == REQ_CLEAR);
    assign wr_addr  = match_any ? match_idx : free_idx;
    assign out_free = !res_valid_reg || res_ready;

    assign cand_key  = key_reg[scan_idx_reg];
    assign cand_ok   = used_reg[scan_idx_reg]
                     && (!prev_valid_reg || (cand_key > prev_key_reg))
                     && (!best_valid_reg || (cand_key < best_key_reg));
    assign scan_last = (scan_idx_reg == IW'(MAX_GROUPS - 1));

    assign count_ext   = NW'(count_reg);
    assign frame_limit = (count_ext > NW'(RESULT_LIMIT)) ? NW'(RESULT_LIMIT) : count_ext;
    assign frame_last  = ((frame_cnt_reg + NW'(1)) == frame_limit);

    assign sts.flush_frames = (type_reg == REQ_FLUSH) && (count_reg != '0);
    assign sts.out_free     = out_free;
    assign sts.scan_last    = scan_last;
    assign sts.frame_last   = frame_last;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            type_reg    <= req_type;
            cmdv_reg    <= cmd_valid;
            bus_reg     <= bus_number;
            ident_reg   <= frame_ident;
            width_reg   <= slot_width;
            total_reg   <= slot_total;
            pos_reg     <= slot_position;
            payload_reg <= slot_payload;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= '0;
            count_reg <= '0;
        end
        else if (do_clear)
        begin
            used_reg  <= '0;
            count_reg <= '0;
        end
        else if (alloc)
        begin
            used_reg[free_idx] <= 1'b1;
            count_reg          <= count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (alloc)
        begin
            key_reg[free_idx] <= key_cmd;
        end
    end

    // A new group writes every byte so the bytes outside the slot start at zero.
    always_ff @(posedge clk)
    begin
        for (int b = 0; b < FRAME_BYTES; b++)
        begin
            if (commit && (byte_sel[b] || alloc))
            begin
                frame_mem[wr_addr][8*b +: 8] <= wr_word[8*b +: 8];
            end
        end
        rd_data_reg <= frame_mem[best_idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg   <= '0;
            best_valid_reg <= 1'b0;
            prev_valid_reg <= 1'b0;
            frame_cnt_reg  <= '0;
        end
        else if (cmd.scan_init)
        begin
            scan_idx_reg   <= '0;
            best_valid_reg <= 1'b0;
            prev_valid_reg <= 1'b0;
            frame_cnt_reg  <= '0;
        end
        else if (cmd.scan_step)
        begin
            scan_idx_reg <= scan_last ? '0 : scan_idx_reg + IW'(1);
            if (cand_ok)
            begin
                best_valid_reg <= 1'b1;
            end
        end
        else if (cmd.emit_frame)
        begin
            best_valid_reg <= 1'b0;
            prev_valid_reg <= 1'b1;
            frame_cnt_reg  <= frame_cnt_reg + NW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_step && cand_ok)
        begin
            best_idx_reg <= scan_idx_reg;
            best_key_reg <= cand_key;
        end
        if (cmd.emit_frame)
        begin
            prev_key_reg <= best_key_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (cmd.finish || cmd.emit_frame)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_bus_reg   <= '0;
            out_ident_reg <= '0;
            out_data_reg  <= '0;
            status_reg    <= finish_code;
            last_reg      <= 1'b1;
        end
        else if (cmd.emit_frame)
        begin
            out_bus_reg   <= best_key_reg[KEY_W-1 -: BUS_W];
            out_ident_reg <= best_key_reg[2*GEOM_W +: IDENT_W];
            out_data_reg  <= rd_data_reg;
            status_reg    <= STS_OK;
            last_reg      <= frame_last;
        end
    end

    assign res_valid   = res_valid_reg;
    assign out_bus     = out_bus_reg;
    assign out_ident   = out_ident_reg;
    assign out_data    = out_data_reg;
    assign status      = status_reg;
    assign last_result = last_reg;

    // The group count tracks the number of occupied entries.
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CW'($countones(used_reg)))
        else $error("group count differs from occupied entries");

    // Every emitted frame comes from a scan that found a group.
    a_emit_found: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_frame |-> best_valid_reg)
        else $error("frame emitted without a selected group");

    // A new group is only placed in a free entry.
    a_alloc_free: assert property (@(posedge clk) disable iff (!rst_n)
        alloc |-> (free_any && !used_reg[free_idx]))
        else $error("allocation into an occupied entry");

    // Flushed frames come out in strictly ascending key order.
    a_flush_order: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_frame && prev_valid_reg) |-> (best_key_reg > prev_key_reg))
        else $error("flush order is not ascending");

endmodule

/* hdl/can_slot_frame_aggregator.sv */
// Ingest, clear and other requests load their single status beat when the decode state ends,
// which it does once the result register is free.
// Flush: the decode state starts a key scan over the table; each frame beat then follows the
// scan and one registered frame memory read, and is loaded once the result register is free.
// An empty table answers like an ingest, with a single status beat.
// One request at a time: the next is taken the cycle after the last beat is loaded,
// even while that beat waits.
// Reset clears the occupancy bits and group count at once; no clearing pass is needed.
module can_slot_frame_aggregator
    import csfa_pkg::*;
#(
    parameter int MAX_GROUPS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  logic [1:0]          req_type,
    input  logic                cmd_valid,
    input  logic [BUS_W-1:0]    bus_number,
    input  logic [IDENT_W-1:0]  frame_ident,
    input  logic [GEOM_W-1:0]   slot_width,
    input  logic [GEOM_W-1:0]   slot_total,
    input  logic [GEOM_W-1:0]   slot_position,
    input  logic [DATA_W-1:0]   slot_payload,
    output logic                res_valid,
    input  logic                res_ready,
    output logic [BUS_W-1:0]    out_bus,
    output logic [IDENT_W-1:0]  out_ident,
    output logic [DATA_W-1:0]   out_data,
    output logic [STATUS_W-1:0] status,
    output logic                last_result
);

    csfa_cmd_t cmd;
    csfa_sts_t sts;

    csfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    csfa_dp #(
        .MAX_GROUPS (MAX_GROUPS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .req_type      (req_type),
        .cmd_valid     (cmd_valid),
        .bus_number    (bus_number),
        .frame_ident   (frame_ident),
        .slot_width    (slot_width),
        .slot_total    (slot_total),
        .slot_position (slot_position),
        .slot_payload  (slot_payload),
        .res_ready     (res_ready),
        .res_valid     (res_valid),
        .out_bus       (out_bus),
        .out_ident     (out_ident),
        .out_data      (out_data),
        .status        (status),
        .last_result   (last_result)
    );

endmodule

/* sim/csfa_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the slot frame aggregator: tracks the group table and checks every result beat.
module csfa_checker
    import csfa_pkg::*;
#(
    parameter int MAX_GROUPS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_ready,
    input  logic [1:0]          req_type,
    input  logic                cmd_valid,
    input  logic [BUS_W-1:0]    bus_number,
    input  logic [IDENT_W-1:0]  frame_ident,
    input  logic [GEOM_W-1:0]   slot_width,
    input  logic [GEOM_W-1:0]   slot_total,
    input  logic [GEOM_W-1:0]   slot_position,
    input  logic [DATA_W-1:0]   slot_payload,
    input  logic                res_valid,
    input  logic                res_ready,
    input  logic [BUS_W-1:0]    out_bus,
    input  logic [IDENT_W-1:0]  out_ident,
    input  logic [DATA_W-1:0]   out_data,
    input  logic [STATUS_W-1:0] status,
    input  logic                last_result,
    output int                  mismatches,
    output int                  in_flight
);

    typedef struct packed {
        logic [BUS_W-1:0]    bus;
        logic [IDENT_W-1:0]  ident;
        logic [DATA_W-1:0]   data;
        logic [STATUS_W-1:0] sts;
        logic                last;
    } frame_beat_t;

    logic              group_used  [MAX_GROUPS];
    logic [KEY_W-1:0]  group_key   [MAX_GROUPS];
    logic [DATA_W-1:0] group_bytes [MAX_GROUPS];
    frame_beat_t       awaited_beats [$];

    function automatic void await_beat(input frame_beat_t beat);
        awaited_beats = {awaited_beats, beat};
    endfunction

    function automatic frame_beat_t status_beat(input csfa_status_t sts);
        frame_beat_t beat;
        beat      = '0;
        beat.sts  = sts;
        beat.last = 1'b1;
        return beat;
    endfunction

    // Status checks run in a fixed order; only a fully valid ingest touches the table.
    task automatic ingest_slot(output csfa_status_t sts);
        logic [KEY_W-1:0] key;
        int hit;
        int spare;
        int base;
        int i;
        hit   = -1;
        spare = -1;
        key   = {bus_number, frame_ident, slot_width, slot_total};
        if (!cmd_valid)
            sts = STS_IGNORED;
        else if (slot_width == 0 || slot_total == 0)
            sts = STS_ZERO_SIZE;
        else if (slot_position >= slot_total)
            sts = STS_INDEX_RANGE;
        else if (int'(slot_width) * int'(slot_total) > FRAME_BYTES)
            sts = STS_OVER_BYTES;
        else
        begin
            for (i = 0; i < MAX_GROUPS; i++)
            begin
                if (group_used[i])
                begin
                    if (group_key[i] == key)
                        hit = i;
                end
                else if (spare < 0)
                    spare = i;
            end
            if (hit < 0 && spare < 0)
                sts = STS_TABLE_FULL;
            else
            begin
                if (hit < 0)
                begin
                    hit               = spare;
                    group_used[hit]   = 1'b1;
                    group_key[hit]    = key;
                    group_bytes[hit]  = '0;
                end
                base = int'(slot_position) * int'(slot_width);
                for (i = 0; i < int'(slot_width); i++)
                    group_bytes[hit][8 * (base + i) +: 8] = slot_payload[8 * i +: 8];
                sts = STS_OK;
            end
        end
    endtask

    // Frames leave in ascending key order; keys of used entries are unique.
    task automatic flush_groups();
        logic        taken [MAX_GROUPS];
        int          total;
        int          emitted;
        int          best;
        int          i;
        frame_beat_t beat;
        total = 0;
        for (i = 0; i < MAX_GROUPS; i++)
        begin
            taken[i] = 1'b0;
            if (group_used[i])
                total++;
        end
        if (total == 0)
            await_beat(status_beat(STS_NO_FRAMES));
        else
        begin
            if (total > RESULT_LIMIT)
                total = RESULT_LIMIT;
            for (emitted = 0; emitted < total; emitted++)
            begin
                best = -1;
                for (i = 0; i < MAX_GROUPS; i++)
                begin
                    if (group_used[i] && !taken[i])
                    begin
                        if (best < 0)
                            best = i;
                        else if (group_key[i] < group_key[best])
                            best = i;
                    end
                end
                taken[best] = 1'b1;
                beat.bus    = group_key[best][KEY_W-1 -: BUS_W];
                beat.ident  = group_key[best][KEY_W-BUS_W-1 -: IDENT_W];
                beat.data   = group_bytes[best];
                beat.sts    = STS_OK;
                beat.last   = (emitted == total - 1);
                await_beat(beat);
            end
        end
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        frame_beat_t  want;
        csfa_status_t sts;
        int           i;
        if (!rst_n)
        begin
            for (i = 0; i < MAX_GROUPS; i++)
                group_used[i] = 1'b0;
            awaited_beats.delete();
            mismatches = 0;
            in_flight <= 0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (awaited_beats.size() == 0)
                begin
                    $error("result beat with nothing awaited: status %0d", status);
                    mismatches++;
                end
                else
                begin
                    want = awaited_beats.pop_front();
                    compare_field("out_bus", 64'(want.bus), 64'(out_bus));
                    compare_field("out_ident", 64'(want.ident), 64'(out_ident));
                    compare_field("out_data", want.data, out_data);
                    compare_field("status", 64'(want.sts), 64'(status));
                    compare_field("last_result", 64'(want.last), 64'(last_result));
                end
            end
            if (req_valid && req_ready)
            begin
                case (req_type)
                    REQ_INGEST:
                    begin
                        ingest_slot(sts);
                        await_beat(status_beat(sts));
                    end
                    REQ_CLEAR:
                    begin
                        for (i = 0; i < MAX_GROUPS; i++)
                            group_used[i] = 1'b0;
                        await_beat(status_beat(STS_OK));
                    end
                    REQ_FLUSH:
                        flush_groups();
                    default:
                        await_beat(status_beat(STS_IGNORED));
                endcase
            end
            in_flight <= awaited_beats.size();
        end
    end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// Top of the aggregator testbench: clock, reset, request stimulus, result stalls and verdict.
module testbench;
    import csfa_pkg::*;

    localparam int         MAX_GROUPS  = 16;
    localparam int         ITEM_TARGET = 500;
    localparam int         CALM_TAIL   = 60;
    localparam int         POOL_MAX    = 24;
    localparam int         CYCLE_LIMIT = 1000000;
    localparam logic [1:0] REQ_SPARE   = 2'd3;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                req_valid     = 1'b0;
    logic                req_ready;
    logic [1:0]          req_type      = '0;
    logic                cmd_valid     = 1'b0;
    logic [BUS_W-1:0]    bus_number    = '0;
    logic [IDENT_W-1:0]  frame_ident   = '0;
    logic [GEOM_W-1:0]   slot_width    = '0;
    logic [GEOM_W-1:0]   slot_total    = '0;
    logic [GEOM_W-1:0]   slot_position = '0;
    logic [DATA_W-1:0]   slot_payload  = '0;
    logic                res_valid;
    logic                res_ready     = 1'b0;
    logic [BUS_W-1:0]    out_bus;
    logic [IDENT_W-1:0]  out_ident;
    logic [DATA_W-1:0]   out_data;
    logic [STATUS_W-1:0] status;
    logic                last_result;

    int mismatches;
    int in_flight;
    int items_sent  = 0;
    int cycle_count = 0;
    int stall_left  = 0;
    bit idle_on     = 1'b0;

    logic [BUS_W-1:0]   pool_bus   [POOL_MAX];
    logic [IDENT_W-1:0] pool_ident [POOL_MAX];
    logic [GEOM_W-1:0]  pool_w     [POOL_MAX];
    logic [GEOM_W-1:0]  pool_n     [POOL_MAX];

    can_slot_frame_aggregator #(.MAX_GROUPS(MAX_GROUPS)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .req_type     (req_type),
        .cmd_valid    (cmd_valid),
        .bus_number   (bus_number),
        .frame_ident  (frame_ident),
        .slot_width   (slot_width),
        .slot_total   (slot_total),
        .slot_position(slot_position),
        .slot_payload (slot_payload),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .out_bus      (out_bus),
        .out_ident    (out_ident),
        .out_data     (out_data),
        .status       (status),
        .last_result  (last_result)
    );

    csfa_checker #(.MAX_GROUPS(MAX_GROUPS)) scoreboard (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .req_type     (req_type),
        .cmd_valid    (cmd_valid),
        .bus_number   (bus_number),
        .frame_ident  (frame_ident),
        .slot_width   (slot_width),
        .slot_total   (slot_total),
        .slot_position(slot_position),
        .slot_payload (slot_payload),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .out_bus      (out_bus),
        .out_ident    (out_ident),
        .out_data     (out_data),
        .status       (status),
        .last_result  (last_result),
        .mismatches   (mismatches),
        .in_flight    (in_flight)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    // The result side stalls in random bursts, which start only while idling is enabled.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            res_ready  <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 3) == 0)
        begin
            stall_left <= $urandom_range(0, 4);
            res_ready  <= 1'b0;
        end
        else
            res_ready <= 1'b1;
    end

    task automatic send_request(input logic [1:0] kind, input logic flag,
                                input logic [BUS_W-1:0] bus, input logic [IDENT_W-1:0] ident,
                                input logic [GEOM_W-1:0] width, input logic [GEOM_W-1:0] total,
                                input logic [GEOM_W-1:0] position,
                                input logic [DATA_W-1:0] payload);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 2) == 0)
            gap = $urandom_range(1, 5);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid     <= 1'b1;
        req_type      <= kind;
        cmd_valid     <= flag;
        bus_number    <= bus;
        frame_ident   <= ident;
        slot_width    <= width;
        slot_total    <= total;
        slot_position <= position;
        slot_payload  <= payload;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        if (!(kind == REQ_SPARE || (kind == REQ_INGEST && !flag)))
            items_sent++;
    endtask

    // Holds the request side off until every predicted beat has been seen.
    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (in_flight != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int               j;
        int               k;
        int               pick;
        int               pool_size;
        int               phase_len;
        logic [GEOM_W-1:0] fill_w;
        logic [GEOM_W-1:0] fill_n;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        idle_on = 1'b1;

        // Error statuses and the empty flush, each in isolation.
        send_request(REQ_FLUSH, 1'b1, 3'd0, '0, 4'd0, 4'd0, 4'd0, '0);
        send_request(REQ_INGEST, 1'b0, 3'd1, 29'd77, 4'd2, 4'd4, 4'd1, '1);
        send_request(REQ_INGEST, 1'b1, 3'd2, 29'd5, 4'd0, 4'd8, 4'd0, '1);
        send_request(REQ_INGEST, 1'b1, 3'd2, 29'd5, 4'd8, 4'd0, 4'd0, '1);
        send_request(REQ_INGEST, 1'b1, 3'd3, 29'd9, 4'd2, 4'd4, 4'd15, '1);
        send_request(REQ_INGEST, 1'b1, 3'd4, 29'd9, 4'd15, 4'd15, 4'd0, '1);
        send_request(REQ_SPARE, 1'b1, 3'd7, '1, 4'd15, 4'd15, 4'd15, '1);

        // Fill every table entry, hit an existing group, overflow the table, then flush, clear and flush again.
        for (j = 0; j < MAX_GROUPS; j++)
        begin
            fill_w = (j == MAX_GROUPS - 1) ? 4'd8 : GEOM_W'(j % 4 + 1);
            fill_n = GEOM_W'(8 / int'(fill_w));
            send_request(REQ_INGEST, 1'b1, BUS_W'(j),
                         (j == MAX_GROUPS - 1) ? '1 : IDENT_W'(j * 29'h0123457),
                         fill_w, fill_n, fill_n - 4'd1,
                         (j == MAX_GROUPS - 1) ? '1 : (j == 0) ? '0 : {$urandom, $urandom});
        end
        send_request(REQ_INGEST, 1'b1, 3'd0, '0, 4'd1, 4'd8, 4'd0, 64'hA5);
        send_request(REQ_INGEST, 1'b1, 3'd0, 29'd12345, 4'd2, 4'd4, 4'd0, '1);
        send_request(REQ_FLUSH, 1'b0, 3'd0, '0, 4'd0, 4'd0, 4'd0, '0);
        send_request(REQ_CLEAR, 1'b0, 3'd0, '0, 4'd0, 4'd0, 4'd0, '0);
        send_request(REQ_FLUSH, 1'b1, 3'd0, '0, 4'd0, 4'd0, 4'd0, '0);
        wait_drained();

        // Phases of well-formed ingests on a small key pool, with noise, flushes and clears.
        while (items_sent < ITEM_TARGET)
        begin
            idle_on = (items_sent < ITEM_TARGET - CALM_TAIL) && ($urandom_range(0, 3) != 0);
            pool_size = $urandom_range(1, POOL_MAX);
            for (j = 0; j < pool_size; j++)
            begin
                pool_w[j]     = GEOM_W'($urandom_range(1, 8));
                pool_n[j]     = GEOM_W'($urandom_range(1, 8 / int'(pool_w[j])));
                pool_bus[j]   = BUS_W'($urandom_range(0, 7));
                pool_ident[j] = (j > 0 && $urandom_range(0, 3) == 0) ? pool_ident[j - 1]
                                                                      : IDENT_W'($urandom);
            end
            phase_len = $urandom_range(4, 40);
            for (k = 0; k < phase_len; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 80)
                begin
                    j = $urandom_range(0, pool_size - 1);
                    send_request(REQ_INGEST, 1'b1, pool_bus[j], pool_ident[j], pool_w[j],
                                 pool_n[j], GEOM_W'($urandom_range(0, int'(pool_n[j]) - 1)),
                                 {$urandom, $urandom});
                end
                else if (pick < 95)
                    send_request(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                                 BUS_W'($urandom_range(0, 7)), IDENT_W'($urandom),
                                 GEOM_W'($urandom_range(0, 15)), GEOM_W'($urandom_range(0, 15)),
                                 GEOM_W'($urandom_range(0, 15)), {$urandom, $urandom});
                else
                    send_request(REQ_FLUSH, 1'($urandom_range(0, 1)),
                                 BUS_W'($urandom_range(0, 7)), IDENT_W'($urandom),
                                 GEOM_W'($urandom_range(0, 15)), GEOM_W'($urandom_range(0, 15)),
                                 GEOM_W'($urandom_range(0, 15)), {$urandom, $urandom});
            end
            send_request(REQ_FLUSH, 1'($urandom_range(0, 1)),
                         BUS_W'($urandom_range(0, 7)), IDENT_W'($urandom),
                         GEOM_W'($urandom_range(0, 15)), GEOM_W'($urandom_range(0, 15)),
                         GEOM_W'($urandom_range(0, 15)), {$urandom, $urandom});
            if ($urandom_range(0, 2) == 0)
                send_request(REQ_CLEAR, 1'($urandom_range(0, 1)),
                             BUS_W'($urandom_range(0, 7)), IDENT_W'($urandom),
                             GEOM_W'($urandom_range(0, 15)), GEOM_W'($urandom_range(0, 15)),
                             GEOM_W'($urandom_range(0, 15)), {$urandom, $urandom});
            if ($urandom_range(0, 3) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
